[design/setf_pkg.sv]
package setf_pkg;

    localparam int COORD_W = 9;
    localparam int LEFT_W  = 10;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_EDGE  = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_WALK,
        ST_DRAIN,
        ST_QWAIT
    } state_t;

    typedef struct packed {
        func_t                func;
        logic [COORD_W-1:0]   start_x;
        logic [COORD_W-1:0]   start_y;
        logic [COORD_W-1:0]   end_x;
        logic [COORD_W-1:0]   end_y;
        logic [COORD_W-1:0]   query_row;
    } req_item_t;

    typedef struct packed {
        logic [COORD_W-1:0]   span_row;
        logic [LEFT_W-1:0]    span_left;
        logic [COORD_W-1:0]   span_end;
        logic                 span_nonempty;
    } rsp_item_t;

endpackage

[design/setf_ram.sv]
module setf_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/setf_div.sv]
// restoring divider, one quotient bit per cycle
module setf_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W:0]   rem_sh;
    logic             qbit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg, num_reg[NUM_W-1]};
        qbit      = (rem_sh >= {1'b0, den_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            num_next = {num_reg[NUM_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

[design/scanline_edge_table_fill.sv]
// Query: the row is read when the beat is taken; the result loads once the response slot is free, then the next beat.
// Edge: a slope division (skipped for a horizontal edge), then a walk over every row from
// the lower to the upper end point, then a drain state; one table read-modify-write per row.
// Clear: all ROWS table rows, one table row written per cycle.
// Reset: asynchronous; starts the same clearing pass, requests held off until done.
module scanline_edge_table_fill import setf_pkg::*; #(
    parameter int ROWS      = 512,
    parameter int COLS      = 512,
    parameter int FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam int IDX_W = $clog2(ROWS);
    localparam int XW    = $clog2(COLS);
    localparam int LW    = $clog2(COLS + 1);
    localparam int POS_W = XW + FRAC_BITS;
    localparam int RAM_W = LW + XW;

    function automatic logic [IDX_W-1:0] clamp_row(logic [COORD_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'(ROWS - 1))
        begin
            w = 32'(ROWS - 1);
        end
        return w[IDX_W-1:0];
    endfunction

    function automatic logic [XW-1:0] clamp_col(logic [COORD_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'(COLS - 1))
        begin
            w = 32'(COLS - 1);
        end
        return w[XW-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  slope_reg, slope_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  hi_y_reg, hi_y_next;
    logic              neg_reg, neg_next;
    logic              wr_pend_reg;
    logic [IDX_W-1:0]  wr_row_reg;
    logic [XW-1:0]     wr_col_reg;
    logic [IDX_W-1:0]  q_row_reg, q_row_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_item_t         rsp_reg, rsp_next;

    logic              accept;
    logic              rsp_free;
    logic              rsp_load;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [RAM_W-1:0]  wdata;
    logic [RAM_W-1:0]  rdata;
    logic              div_start;
    logic              div_done;
    logic [POS_W-1:0]  div_quot;

    logic [XW-1:0]     sx, ex, lo_x, hi_x, dx_mag;
    logic [IDX_W-1:0]  sy, ey, lo_y, hi_y, dy;
    logic              swap, dx_neg, dy_zero;
    logic [XW-1:0]     col_cur;
    logic [LW-1:0]     old_l, new_l;
    logic [XW-1:0]     old_r, new_r;

    // edge setup
    always_comb
    begin
        sx      = clamp_col(req.start_x);
        sy      = clamp_row(req.start_y);
        ex      = clamp_col(req.end_x);
        ey      = clamp_row(req.end_y);
        swap    = (sy > ey);
        lo_x    = swap ? ex : sx;
        lo_y    = swap ? ey : sy;
        hi_x    = swap ? sx : ex;
        hi_y    = swap ? sy : ey;
        dx_neg  = (hi_x < lo_x);
        dx_mag  = dx_neg ? (lo_x - hi_x) : (hi_x - lo_x);
        dy      = hi_y - lo_y;
        dy_zero = (dy == '0);
    end

    assign col_cur = pos_reg[POS_W-1:FRAC_BITS];
    assign old_l   = rdata[RAM_W-1:XW];
    assign old_r   = rdata[XW-1:0];
    assign new_l   = (LW'(wr_col_reg) < old_l) ? LW'(wr_col_reg) : old_l;
    assign new_r   = (wr_col_reg > old_r) ? wr_col_reg : old_r;
    assign rsp_free = !rsp_valid_reg || rsp_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == IDX_W'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.func)
                        FUNC_CLEAR: state_next = ST_CLEAR;
                        FUNC_EDGE:  state_next = dy_zero ? ST_WALK : ST_DIV;
                        FUNC_QUERY: state_next = ST_QWAIT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (row_reg == hi_y_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_IDLE;
            ST_QWAIT:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        req_ready = (state_reg == ST_IDLE);
        accept    = req_valid && req_ready;
        div_start = accept && (req.func == FUNC_EDGE) && !dy_zero;
        rsp_load  = (state_reg == ST_QWAIT) && rsp_free;
        rd_en     = 1'b0;
        rd_addr   = row_reg;
        if (accept && (req.func == FUNC_QUERY))
        begin
            rd_en   = 1'b1;
            rd_addr = clamp_row(req.query_row);
        end
        else if (state_reg == ST_WALK)
        begin
            rd_en = 1'b1;
        end
        we    = 1'b0;
        waddr = wr_row_reg;
        wdata = {new_l, new_r};
        if (state_reg == ST_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = {LW'(COLS), XW'(0)};
        end
        else if (wr_pend_reg)
        begin
            we = 1'b1;
        end
    end

    // datapath
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        pos_next       = pos_reg;
        slope_next     = slope_reg;
        row_next       = row_reg;
        hi_y_next      = hi_y_reg;
        neg_next       = neg_reg;
        q_row_next     = q_row_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (state_reg == ST_CLEAR)
        begin
            clr_cnt_next = (clr_cnt_reg == IDX_W'(ROWS - 1)) ? '0 : clr_cnt_reg + 1'b1;
        end
        if (accept && (req.func == FUNC_EDGE))
        begin
            pos_next   = {lo_x, {FRAC_BITS{1'b0}}};
            slope_next = '0;
            row_next   = lo_y;
            hi_y_next  = hi_y;
            neg_next   = dx_neg;
        end
        if (accept && (req.func == FUNC_QUERY))
        begin
            q_row_next = clamp_row(req.query_row);
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            slope_next = neg_reg ? (~div_quot + 1'b1) : div_quot;
        end
        if (state_reg == ST_WALK)
        begin
            pos_next = pos_reg + slope_reg;
            row_next = row_reg + 1'b1;
        end
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (rsp_load)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.span_row      = COORD_W'(q_row_reg);
            rsp_next.span_left     = LEFT_W'(old_l);
            rsp_next.span_end      = COORD_W'(old_r);
            rsp_next.span_nonempty = (old_l <= LW'(old_r));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            wr_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            wr_pend_reg   <= (state_reg == ST_WALK);
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        slope_reg  <= slope_next;
        row_reg    <= row_next;
        hi_y_reg   <= hi_y_next;
        neg_reg    <= neg_next;
        q_row_reg  <= q_row_next;
        rsp_reg    <= rsp_next;
        wr_row_reg <= row_reg;
        wr_col_reg <= col_cur;
    end

    setf_div #(
        .NUM_W (POS_W),
        .DEN_W (IDX_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({dx_mag, {FRAC_BITS{1'b0}}}),
        .den   (dy),
        .done  (div_done),
        .quot  (div_quot)
    );

    setf_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside slope phase");

    a_rmw_row: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> (wr_row_reg == $past(rd_addr)))
        else $error("write-back row differs from row read");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (32'(col_cur) <= 32'(COLS - 1)))
        else $error("walking column left the table");

    a_no_clear_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !wr_pend_reg)
        else $error("clearing pass overlaps edge write-back");

endmodule
